>>> design/ipp_pkg.sv
package ipp_pkg;

  localparam int MAX_IDS     = 256;
  localparam int PRIO_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_IDS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PRIO_BITS-1:0] prio_t;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  typedef struct packed {
    op_t   op;
    idx_t  idx;
    prio_t prio;
  } qent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } st_t;

  function automatic idx_t id_to_idx(input logic [7:0] id);
    logic [IDX_W+7:0] w;
    w = {{IDX_W{1'b0}}, id};
    return w[IDX_W-1:0];
  endfunction

  function automatic logic [7:0] idx_to_id(input idx_t idx);
    logic [IDX_W+7:0] w;
    w = {8'h00, idx};
    return w[7:0];
  endfunction

  function automatic prio_t fit_prio(input logic [15:0] p);
    logic [PRIO_BITS+15:0] w;
    w = {{PRIO_BITS{1'b0}}, p};
    return w[PRIO_BITS-1:0];
  endfunction

endpackage

>>> design/ipp_front.sv
module ipp_front (
  input  logic          start,
  input  logic          in_cmd,
  input  logic [7:0]    in_event_id,
  input  logic [15:0]   in_priority_req,
  input  logic          q_full,
  output logic          busy,
  output logic          q_push,
  output ipp_pkg::qent_t q_entry
);
  import ipp_pkg::*;

  logic accept;
  logic in_range;

  assign busy     = q_full;
  assign accept   = start && !q_full;
  // sets to ids beyond the table are taken and dropped here
  assign in_range = ({24'h0, in_event_id} < 32'(MAX_IDS));

  always_comb begin
    q_entry.op   = (in_cmd == 1'b1) ? OP_POLL : OP_SET;
    q_entry.idx  = id_to_idx(in_event_id);
    q_entry.prio = fit_prio(in_priority_req);
  end

  assign q_push = accept && ((q_entry.op == OP_POLL) || in_range);

endmodule

>>> design/ipp_queue.sv
module ipp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ipp_pkg::qent_t push_entry,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output ipp_pkg::qent_t head
);
  import ipp_pkg::*;

  qent_t             slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_entry;
  end

endmodule

>>> design/ipp_back.sv
module ipp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ipp_pkg::qent_t q_head,
  output logic           q_pop,
  output logic           out_strobe,
  output logic           out_found,
  output logic [7:0]     out_polled_id
);
  import ipp_pkg::*;

  localparam idx_t LAST_IDX = IDX_W'(MAX_IDS - 1);

  st_t   state_r;
  st_t   state_nxt;

  prio_t mem [MAX_IDS];
  logic [MAX_IDS-1:0] present_r;

  idx_t  cnt_r;
  logic  rd_vld_r;
  idx_t  rd_idx_r;
  prio_t rd_prio_r;
  logic  rd_pres_r;

  logic  have_r;
  idx_t  best_idx_r;
  prio_t best_prio_r;

  logic       out_strobe_r;
  logic       out_found_r;
  logic [7:0] out_id_r;

  logic do_set;
  logic start_scan;
  logic issue;
  logic finish;
  logic take;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid && q_head.op == OP_POLL) state_nxt = ST_SCAN;
      ST_SCAN: if (cnt_r == LAST_IDX) state_nxt = ST_LAST;
      ST_LAST: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop      = 1'b0;
    do_set     = 1'b0;
    start_scan = 1'b0;
    issue      = 1'b0;
    finish     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_pop      = q_valid;
        do_set     = q_valid && (q_head.op == OP_SET);
        start_scan = q_valid && (q_head.op == OP_POLL);
      end
      ST_SCAN: issue  = 1'b1;
      ST_LAST: ;
      ST_DONE: finish = 1'b1;
      default: ;
    endcase
  end

  // strict greater keeps the smallest id on ties
  assign take = rd_vld_r && rd_pres_r && (!have_r || (rd_prio_r > best_prio_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      have_r       <= 1'b0;
      present_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= issue;
      out_strobe_r <= finish;
      if (start_scan) cnt_r <= '0;
      else if (issue) cnt_r <= cnt_r + 1'b1;
      if (start_scan) have_r <= 1'b0;
      else if (take)  have_r <= 1'b1;
      if (do_set) present_r[q_head.idx] <= 1'b1;
      if (finish && have_r) present_r[best_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_set) mem[q_head.idx] <= q_head.prio;
    rd_prio_r <= mem[cnt_r];
    rd_pres_r <= present_r[cnt_r];
    rd_idx_r  <= cnt_r;
    if (take) begin
      best_idx_r  <= rd_idx_r;
      best_prio_r <= rd_prio_r;
    end
    if (finish) begin
      out_found_r <= have_r;
      out_id_r    <= have_r ? idx_to_id(best_idx_r) : 8'h00;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_found     = out_found_r;
  assign out_polled_id = out_id_r;

  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == ST_DONE))
    else $error("result strobe without a finished scan");

  a_polled_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_found_r) |-> !present_r[best_idx_r])
    else $error("polled entry still marked present");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN || state_r == ST_LAST))
    else $error("scan read data outside of a scan");

  a_scan_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && $past(state_r == ST_IDLE)) |-> (cnt_r == '0))
    else $error("scan did not start at entry zero");

endmodule

>>> design/indexed_priority_poll_table.sv
// indexed priority poll table
// input channel: start with in_cmd, in_event_id, in_priority_req; a transfer
//   happens at a rising edge with start high and busy low
// in_cmd = 0 (set): writes the id's priority and marks it present, no result;
//   ids beyond the table are taken and dropped
// in_cmd = 1 (poll): returns the present id with the highest priority, smallest
//   id on ties, and clears it; out_found = 0 and out_polled_id = 0 when empty
// result channel: out_strobe high for one cycle with out_found, out_polled_id;
//   the receiver takes every result, there is no stall on this side
// structure: a front stage classifies items into a two-entry queue, the back
//   engine runs them; a set is written from the idle state, a poll walks
//   every table entry through the priority memory read port, one entry a
//   cycle, and then shows its result on the result channel
// busy is high while the queue is full; with polls back to back the front
//   stalls until the engine takes the next item from the queue
// reset: all present flags clear at once, the queue empties; priorities are
//   unknown until set, and only entries marked present are ever compared
module indexed_priority_poll_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [7:0]  in_event_id,
  input  logic [15:0] in_priority_req,
  output logic        out_strobe,
  output logic        out_found,
  output logic [7:0]  out_polled_id
);
  import ipp_pkg::*;

  // front to queue
  logic  q_push;
  qent_t q_entry;
  logic  q_full;

  // queue to back engine
  logic  q_valid;
  qent_t q_head;
  logic  q_pop;

  // classify and hand over to the queue
  ipp_front u_front (
    .start           (start),
    .in_cmd          (in_cmd),
    .in_event_id     (in_event_id),
    .in_priority_req (in_priority_req),
    .q_full          (q_full),
    .busy            (busy),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  // short queue so the front keeps taking items while a poll scans
  ipp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  // table memory, present flags and the polling scan
  ipp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_strobe    (out_strobe),
    .out_found     (out_found),
    .out_polled_id (out_polled_id)
  );

endmodule
